// File: rtl/jbst_pkg.sv
package jbst_pkg;

    localparam int POSITION_BITS = 16;
    localparam int OUT_BITS      = 16;
    localparam int MAX_RESULTS   = 4;
    localparam int CNT_BITS      = 3;

    typedef logic [POSITION_BITS-1:0] pos_t;

    typedef enum logic [4:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_STR, M_ESC, M_HEX1, M_SURR_BS, M_SURR_U,
        M_HEX2, M_NUM_SIGN, M_NUM_DIGITS, M_NUM_FRAC, M_NUM_EXP, M_NUM_EXPSIGN,
        M_IDENT, M_HALT
    } mode_t;

    localparam logic [1:0] REC_DATA  = 2'd0;
    localparam logic [1:0] REC_TOKEN = 2'd1;
    localparam logic [1:0] REC_ERROR = 2'd2;

    localparam logic [3:0] TK_END    = 4'd0;
    localparam logic [3:0] TK_STRING = 4'd1;
    localparam logic [3:0] TK_INT    = 4'd2;
    localparam logic [3:0] TK_FLOAT  = 4'd3;
    localparam logic [3:0] TK_BOOL   = 4'd4;
    localparam logic [3:0] TK_NULL   = 4'd5;
    localparam logic [3:0] TK_COMMA  = 4'd6;
    localparam logic [3:0] TK_COLON  = 4'd7;
    localparam logic [3:0] TK_LBRACE = 4'd8;
    localparam logic [3:0] TK_RBRACE = 4'd9;
    localparam logic [3:0] TK_LBRACK = 4'd10;
    localparam logic [3:0] TK_RBRACK = 4'd11;

    localparam logic [3:0] ER_NONE    = 4'd0;
    localparam logic [3:0] ER_COMMENT = 4'd1;
    localparam logic [3:0] ER_HEX     = 4'd2;
    localparam logic [3:0] ER_SURR    = 4'd3;
    localparam logic [3:0] ER_UNICODE = 4'd4;
    localparam logic [3:0] ER_STRING  = 4'd5;
    localparam logic [3:0] ER_ESCAPE  = 4'd6;
    localparam logic [3:0] ER_DIGIT   = 4'd7;
    localparam logic [3:0] ER_EXP2    = 4'd8;
    localparam logic [3:0] ER_POINT   = 4'd9;
    localparam logic [3:0] ER_NUMCHAR = 4'd10;
    localparam logic [3:0] ER_CHAR    = 4'd11;
    localparam logic [3:0] ER_IDENT   = 4'd12;

    localparam logic [0:0] CFG_ALLOW_COMMENTS = 1'b0;
    localparam logic [0:0] CFG_ALLOW_ESCAPE_E = 1'b1;

    typedef struct packed {
        logic [1:0]          kind;
        logic [3:0]          tok;
        logic [7:0]          data;
        logic                bv;
        logic [OUT_BITS-1:0] row;
        logic [OUT_BITS-1:0] col;
        logic [3:0]          err;
    } rec_t;

    typedef struct packed {
        logic [CNT_BITS-1:0] count;
        rec_t [MAX_RESULTS-1:0] recs;
    } batch_t;

    function automatic logic [OUT_BITS-1:0] clip(input pos_t v);
        if (POSITION_BITS > OUT_BITS && (v >> OUT_BITS) != '0)
            return '1;
        return OUT_BITS'(v);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

endpackage

// File: rtl/jbst_core.sv
module jbst_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        in_byte,
    input  logic              in_end,
    input  logic              allow_comments,
    input  logic              allow_escape_e,
    output jbst_pkg::batch_t  batch
);
    import jbst_pkg::*;

    mode_t       mode_reg, mode_next;
    pos_t        row_reg, row_next, col_reg, col_next;
    pos_t        srow_reg, srow_next, scol_reg, scol_next;
    pos_t        ecol_reg, ecol_next;
    logic [15:0] hacc_reg, hacc_next, hsur_reg, hsur_next;
    logic [1:0]  hcnt_reg, hcnt_next;
    logic [1:0]  nflg_reg, nflg_next;
    logic [3:0]  kw_reg, kw_next;
    logic        star_reg, star_next;

    // Keyword matcher: state is position in "null","true","false" chain
    function automatic logic [3:0] kw_step(input logic [3:0] m, input logic [7:0] c);
        logic [7:0] want;
        want = 8'd0;
        case (m)
            4'd1:  want = "u";
            4'd2:  want = "l";
            4'd3:  want = "l";
            4'd5:  want = "r";
            4'd6:  want = "u";
            4'd7:  want = "e";
            4'd9:  want = "a";
            4'd10: want = "l";
            4'd11: want = "s";
            4'd12: want = "e";
            default: want = 8'd0;
        endcase
        if (want != 8'd0 && want == c)
            return m + 4'd1;
        return 4'd0;
    endfunction

    always_comb
    begin
        logic [7:0]  b;
        logic [3:0]  bt;
        logic [3:0]  hv;
        logic        hok;
        logic [15:0] acc;
        logic [20:0] cp;
        logic        do_idle;
        logic        do_utf;
        logic        fin_ok;
        logic        dead;

        mode_next = mode_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        srow_next = srow_reg;
        scol_next = scol_reg;
        ecol_next = ecol_reg;
        hacc_next = hacc_reg;
        hsur_next = hsur_reg;
        hcnt_next = hcnt_reg;
        nflg_next = nflg_reg;
        kw_next   = kw_reg;
        star_next = star_reg;
        batch     = '0;
        b         = in_byte;
        bt        = TK_END;
        hv        = 4'd0;
        hok       = 1'b1;
        acc       = 16'd0;
        cp        = 21'd0;
        do_idle   = 1'b0;
        do_utf    = 1'b0;
        fin_ok    = 1'b1;
        dead      = 1'b0;

        if (b >= "0" && b <= "9")      hv = 4'(b - "0");
        else if (b >= "a" && b <= "f") hv = 4'(b - "a" + 8'd10);
        else if (b >= "A" && b <= "F") hv = 4'(b - "A" + 8'd10);
        else                           hok = 1'b0;
        acc = {hacc_reg[11:0], hv};

        if (in_end) begin
            case (mode_reg)
                M_IDLE: ;
                M_SLASH: begin
                    batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(srow_reg),
                                      clip(scol_reg), ER_CHAR};
                    dead = 1'b1;
                end
                M_COMMENT: begin
                    batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(srow_reg),
                                      clip(scol_reg), ER_COMMENT};
                    dead = 1'b1;
                end
                M_STR, M_ESC: begin
                    batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(srow_reg),
                                      clip(scol_reg), ER_STRING};
                    dead = 1'b1;
                end
                M_HEX1, M_HEX2: begin
                    batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(row_reg),
                                      clip(col_reg), ER_HEX};
                    dead = 1'b1;
                end
                M_SURR_BS: begin
                    batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(srow_reg),
                                      clip(scol_reg), ER_SURR};
                    dead = 1'b1;
                end
                M_SURR_U: begin
                    batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(row_reg),
                                      clip(ecol_reg), ER_UNICODE};
                    dead = 1'b1;
                end
                M_NUM_SIGN, M_NUM_FRAC, M_NUM_EXP, M_NUM_EXPSIGN: begin
                    batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(row_reg),
                                      clip(col_reg), ER_DIGIT};
                    dead = 1'b1;
                end
                M_NUM_DIGITS: begin
                    batch.recs[0] = '{REC_TOKEN, (nflg_reg != 2'd0) ? TK_FLOAT : TK_INT,
                                      8'd0, 1'b0, clip(srow_reg), clip(scol_reg), ER_NONE};
                    batch.count = 3'd1;
                end
                M_IDENT: begin
                    if (kw_reg == 4'd4)
                        batch.recs[0] = '{REC_TOKEN, TK_NULL, 8'd0, 1'b0, clip(srow_reg),
                                          clip(scol_reg), ER_NONE};
                    else if (kw_reg == 4'd8 || kw_reg == 4'd13)
                        batch.recs[0] = '{REC_TOKEN, TK_BOOL, 8'd0, kw_reg == 4'd8,
                                          clip(srow_reg), clip(scol_reg), ER_NONE};
                    else begin
                        batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(srow_reg),
                                          clip(scol_reg), ER_IDENT};
                        dead = 1'b1;
                    end
                    batch.count = 3'd1;
                end
                default: dead = 1'b1;
            endcase
            if (dead) begin
                batch.count = (mode_reg == M_HALT) ? 3'd0 : 3'd1;
            end else begin
                batch.recs[batch.count[1:0]] = '{REC_TOKEN, TK_END, 8'd0, 1'b0, clip(row_reg),
                                                 clip(col_reg), ER_NONE};
                batch.count = batch.count + 3'd1;
            end
            mode_next = M_IDLE;
            row_next  = pos_t'(1);
            col_next  = pos_t'(1);
            srow_next = pos_t'(1);
            scol_next = pos_t'(1);
            ecol_next = pos_t'(1);
            hacc_next = 16'd0;
            hsur_next = 16'd0;
            hcnt_next = 2'd0;
            nflg_next = 2'd0;
            kw_next   = 4'd0;
            star_next = 1'b0;
        end else begin
            case (mode_reg)
                M_IDLE: do_idle = 1'b1;
                M_SLASH:
                    if (b == "*") begin
                        mode_next = M_COMMENT;
                        star_next = 1'b0;
                    end else begin
                        batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(srow_reg),
                                          clip(scol_reg), ER_CHAR};
                        batch.count = 3'd1;
                        mode_next = M_HALT;
                    end
                M_COMMENT:
                    if (star_reg && b == "/") mode_next = M_IDLE;
                    else star_next = (b == "*");
                M_STR:
                    if (b == "\"") begin
                        batch.recs[0] = '{REC_TOKEN, TK_STRING, 8'd0, 1'b0, clip(srow_reg),
                                          clip(scol_reg), ER_NONE};
                        batch.count = 3'd1;
                        mode_next = M_IDLE;
                    end else if (b == 8'h0A) begin
                        batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(srow_reg),
                                          clip(scol_reg), ER_STRING};
                        batch.count = 3'd1;
                        mode_next = M_HALT;
                    end else if (b == "\\") begin
                        ecol_next = col_reg;
                        mode_next = M_ESC;
                    end else begin
                        batch.recs[0] = '{REC_DATA, TK_END, b, 1'b0, clip(row_reg),
                                          clip(col_reg), ER_NONE};
                        batch.count = 3'd1;
                    end
                M_ESC: begin
                    logic [7:0] e;
                    logic       ok;
                    e  = b;
                    ok = 1'b1;
                    case (b)
                        "\"", "\\", "/": e = b;
                        "b": e = 8'h08;
                        "f": e = 8'h0C;
                        "n": e = 8'h0A;
                        "r": e = 8'h0D;
                        "t": e = 8'h09;
                        "e": begin
                            e  = 8'h1B;
                            ok = allow_escape_e;
                        end
                        default: ok = 1'b0;
                    endcase
                    if (b == "u") begin
                        hacc_next = 16'd0;
                        hcnt_next = 2'd0;
                        mode_next = M_HEX1;
                    end else if (b == 8'h0A) begin
                        batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(srow_reg),
                                          clip(scol_reg), ER_STRING};
                        batch.count = 3'd1;
                        mode_next = M_HALT;
                    end else if (!ok) begin
                        batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(row_reg),
                                          clip(ecol_reg), ER_ESCAPE};
                        batch.count = 3'd1;
                        mode_next = M_HALT;
                    end else begin
                        batch.recs[0] = '{REC_DATA, TK_END, e, 1'b0, clip(row_reg),
                                          clip(col_reg), ER_NONE};
                        batch.count = 3'd1;
                        mode_next = M_STR;
                    end
                end
                M_HEX1, M_HEX2:
                    if (!hok) begin
                        batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(row_reg),
                                          clip(col_reg), ER_HEX};
                        batch.count = 3'd1;
                        mode_next = M_HALT;
                    end else begin
                        hacc_next = acc;
                        if (hcnt_reg != 2'd3) hcnt_next = hcnt_reg + 2'd1;
                        else begin
                            hcnt_next = 2'd0;
                            if (mode_reg == M_HEX1) begin
                                if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
                                    hsur_next = acc;
                                    mode_next = M_SURR_BS;
                                end else begin
                                    cp = {5'd0, acc};
                                    do_utf = 1'b1;
                                    mode_next = M_STR;
                                end
                            end else if (acc < 16'hDC00 || acc > 16'hDFFF) begin
                                batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(row_reg),
                                                  clip(ecol_reg), ER_UNICODE};
                                batch.count = 3'd1;
                                mode_next = M_HALT;
                            end else begin
                                cp = 21'h10000 + {1'b0, hsur_reg[9:0], acc[9:0]};
                                do_utf = 1'b1;
                                mode_next = M_STR;
                            end
                        end
                    end
                M_SURR_BS:
                    if (b == "\\") mode_next = M_SURR_U;
                    else begin
                        batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(row_reg),
                                          clip(ecol_reg), ER_UNICODE};
                        batch.count = 3'd1;
                        mode_next = M_HALT;
                    end
                M_SURR_U:
                    if (b == "u") begin
                        hacc_next = 16'd0;
                        hcnt_next = 2'd0;
                        mode_next = M_HEX2;
                    end else begin
                        batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(row_reg),
                                          clip(ecol_reg), ER_UNICODE};
                        batch.count = 3'd1;
                        mode_next = M_HALT;
                    end
                M_NUM_SIGN, M_NUM_FRAC, M_NUM_EXPSIGN, M_NUM_EXP:
                    if (is_digit(b) || (mode_reg == M_NUM_EXP && (b == "+" || b == "-"))) begin
                        batch.recs[0] = '{REC_DATA, TK_END, b, 1'b0, clip(row_reg),
                                          clip(col_reg), ER_NONE};
                        batch.count = 3'd1;
                        mode_next = is_digit(b) ? M_NUM_DIGITS : M_NUM_EXPSIGN;
                    end else begin
                        batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(row_reg),
                                          clip(col_reg), ER_DIGIT};
                        batch.count = 3'd1;
                        mode_next = M_HALT;
                    end
                M_NUM_DIGITS:
                    if (is_digit(b)) begin
                        batch.recs[0] = '{REC_DATA, TK_END, b, 1'b0, clip(row_reg),
                                          clip(col_reg), ER_NONE};
                        batch.count = 3'd1;
                    end else if (b == "e" || b == "E") begin
                        if (nflg_reg[1]) begin
                            batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(row_reg),
                                              clip(col_reg), ER_EXP2};
                            mode_next = M_HALT;
                        end else begin
                            batch.recs[0] = '{REC_DATA, TK_END, b, 1'b0, clip(row_reg),
                                              clip(col_reg), ER_NONE};
                            nflg_next = nflg_reg | 2'b10;
                            mode_next = M_NUM_EXP;
                        end
                        batch.count = 3'd1;
                    end else if (b == ".") begin
                        if (nflg_reg != 2'd0) begin
                            batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(row_reg),
                                              clip(col_reg), ER_POINT};
                            mode_next = M_HALT;
                        end else begin
                            batch.recs[0] = '{REC_DATA, TK_END, b, 1'b0, clip(row_reg),
                                              clip(col_reg), ER_NONE};
                            nflg_next = 2'b01;
                            mode_next = M_NUM_FRAC;
                        end
                        batch.count = 3'd1;
                    end else if (b == "-" || is_alpha(b)) begin
                        batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(row_reg),
                                          clip(col_reg), ER_NUMCHAR};
                        batch.count = 3'd1;
                        mode_next = M_HALT;
                    end else begin
                        batch.recs[0] = '{REC_TOKEN, (nflg_reg != 2'd0) ? TK_FLOAT : TK_INT,
                                          8'd0, 1'b0, clip(srow_reg), clip(scol_reg), ER_NONE};
                        batch.count = 3'd1;
                        mode_next = M_IDLE;
                        do_idle = 1'b1;
                    end
                M_IDENT:
                    if (is_alpha(b) || is_digit(b)) kw_next = kw_step(kw_reg, b);
                    else begin
                        if (kw_reg == 4'd4)
                            batch.recs[0] = '{REC_TOKEN, TK_NULL, 8'd0, 1'b0, clip(srow_reg),
                                              clip(scol_reg), ER_NONE};
                        else if (kw_reg == 4'd8 || kw_reg == 4'd13)
                            batch.recs[0] = '{REC_TOKEN, TK_BOOL, 8'd0, kw_reg == 4'd8,
                                              clip(srow_reg), clip(scol_reg), ER_NONE};
                        else begin
                            batch.recs[0] = '{REC_ERROR, TK_END, 8'd0, 1'b0, clip(srow_reg),
                                              clip(scol_reg), ER_IDENT};
                            fin_ok = 1'b0;
                            mode_next = M_HALT;
                        end
                        batch.count = 3'd1;
                        if (fin_ok) begin
                            mode_next = M_IDLE;
                            do_idle = 1'b1;
                        end
                    end
                default: mode_next = M_HALT;
            endcase

            // Expand a code point into UTF-8 bytes
            if (do_utf && cp != 21'd0) begin
                if (cp <= 21'h7F) begin
                    batch.recs[0] = '{REC_DATA, TK_END, cp[7:0], 1'b0, clip(row_reg),
                                      clip(col_reg), ER_NONE};
                    batch.count = 3'd1;
                end else if (cp <= 21'h7FF) begin
                    batch.recs[0] = '{REC_DATA, TK_END, 8'hC0 | {3'd0, cp[10:6]}, 1'b0,
                                      clip(row_reg), clip(col_reg), ER_NONE};
                    batch.recs[1] = '{REC_DATA, TK_END, 8'h80 | {2'd0, cp[5:0]}, 1'b0,
                                      clip(row_reg), clip(col_reg), ER_NONE};
                    batch.count = 3'd2;
                end else if (cp <= 21'hFFFF) begin
                    batch.recs[0] = '{REC_DATA, TK_END, 8'hE0 | {4'd0, cp[15:12]}, 1'b0,
                                      clip(row_reg), clip(col_reg), ER_NONE};
                    batch.recs[1] = '{REC_DATA, TK_END, 8'h80 | {2'd0, cp[11:6]}, 1'b0,
                                      clip(row_reg), clip(col_reg), ER_NONE};
                    batch.recs[2] = '{REC_DATA, TK_END, 8'h80 | {2'd0, cp[5:0]}, 1'b0,
                                      clip(row_reg), clip(col_reg), ER_NONE};
                    batch.count = 3'd3;
                end else begin
                    batch.recs[0] = '{REC_DATA, TK_END, 8'hF0 | {5'd0, cp[20:18]}, 1'b0,
                                      clip(row_reg), clip(col_reg), ER_NONE};
                    batch.recs[1] = '{REC_DATA, TK_END, 8'h80 | {2'd0, cp[17:12]}, 1'b0,
                                      clip(row_reg), clip(col_reg), ER_NONE};
                    batch.recs[2] = '{REC_DATA, TK_END, 8'h80 | {2'd0, cp[11:6]}, 1'b0,
                                      clip(row_reg), clip(col_reg), ER_NONE};
                    batch.recs[3] = '{REC_DATA, TK_END, 8'h80 | {2'd0, cp[5:0]}, 1'b0,
                                      clip(row_reg), clip(col_reg), ER_NONE};
                    batch.count = 3'd4;
                end
            end

            // Handle a byte between tokens, possibly after a finished token
            if (do_idle && !is_space(b)) begin
                case (b)
                    "{": bt = TK_LBRACE;
                    "}": bt = TK_RBRACE;
                    "[": bt = TK_LBRACK;
                    "]": bt = TK_RBRACK;
                    ",": bt = TK_COMMA;
                    ":": bt = TK_COLON;
                    default: bt = TK_END;
                endcase
                if (bt != TK_END) begin
                    srow_next = row_reg;
                    scol_next = col_reg;
                    batch.recs[batch.count[1:0]] = '{REC_TOKEN, bt, 8'd0, 1'b0,
                                                     clip(row_reg), clip(col_reg), ER_NONE};
                    batch.count = batch.count + 3'd1;
                end else if (b == "/" && allow_comments) begin
                    srow_next = row_reg;
                    scol_next = col_reg;
                    mode_next = M_SLASH;
                end else if (b == "\"") begin
                    srow_next = row_reg;
                    scol_next = col_reg;
                    mode_next = M_STR;
                end else if (b == "-" || is_digit(b)) begin
                    srow_next = row_reg;
                    scol_next = col_reg;
                    nflg_next = 2'd0;
                    batch.recs[batch.count[1:0]] = '{REC_DATA, TK_END, b, 1'b0,
                                                     clip(row_reg), clip(col_reg), ER_NONE};
                    batch.count = batch.count + 3'd1;
                    mode_next = (b == "-") ? M_NUM_SIGN : M_NUM_DIGITS;
                end else if (is_alpha(b)) begin
                    srow_next = row_reg;
                    scol_next = col_reg;
                    kw_next = (b == "n") ? 4'd1 : ((b == "t") ? 4'd5 :
                              ((b == "f") ? 4'd9 : 4'd0));
                    mode_next = M_IDENT;
                end else begin
                    batch.recs[batch.count[1:0]] = '{REC_ERROR, TK_END, 8'd0, 1'b0,
                                                     clip(row_reg), clip(col_reg), ER_CHAR};
                    batch.count = batch.count + 3'd1;
                    mode_next = M_HALT;
                end
            end

            // Advance the position counters, saturating
            if (b == 8'h0A) begin
                if (row_reg != '1) row_next = row_reg + pos_t'(1);
                col_next = pos_t'(1);
            end else if (col_reg != '1) begin
                col_next = col_reg + pos_t'(1);
            end
        end

        if (!step) begin
            mode_next = mode_reg;
            row_next  = row_reg;
            col_next  = col_reg;
            srow_next = srow_reg;
            scol_next = scol_reg;
            ecol_next = ecol_reg;
            hacc_next = hacc_reg;
            hsur_next = hsur_reg;
            hcnt_next = hcnt_reg;
            nflg_next = nflg_reg;
            kw_next   = kw_reg;
            star_next = star_reg;
        end
    end

    // Hold lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
            row_reg  <= pos_t'(1);
            col_reg  <= pos_t'(1);
            srow_reg <= pos_t'(1);
            scol_reg <= pos_t'(1);
            ecol_reg <= pos_t'(1);
            hacc_reg <= 16'd0;
            hsur_reg <= 16'd0;
            hcnt_reg <= 2'd0;
            nflg_reg <= 2'd0;
            kw_reg   <= 4'd0;
            star_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            srow_reg <= srow_next;
            scol_reg <= scol_next;
            ecol_reg <= ecol_next;
            hacc_reg <= hacc_next;
            hsur_reg <= hsur_next;
            hcnt_reg <= hcnt_next;
            nflg_reg <= nflg_next;
            kw_reg   <= kw_next;
            star_reg <= star_next;
        end
    end

endmodule

// File: rtl/json_byte_stream_tokenizer.sv
// The first result of a request is registered and appears in the cycle after it is accepted.
// Throughput: one byte per cycle while in_stall is low; a byte that yields n results (up to four)
// occupies the result buffer until the single output port has passed all n of them out.
// Reset: lexer idle at row 1 column 1, both options enabled, no results held.
module json_byte_stream_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [0:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  record_kind,
    output logic [3:0]  token_kind,
    output logic [7:0]  data_byte,
    output logic        bool_value,
    output logic [15:0] position_row,
    output logic [15:0] position_column,
    output logic [3:0]  error_code,
    output logic        last_of_run
);
    import jbst_pkg::*;

    logic   allow_comments_reg, allow_escape_e_reg;
    batch_t batch, buf_reg, buf_next;
    logic [CNT_BITS-1:0] idx_reg, idx_next;
    logic   step, pop, buf_busy;

    jbst_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .in_byte        (text_byte),
        .in_end         (end_of_text),
        .allow_comments (allow_comments_reg),
        .allow_escape_e (allow_escape_e_reg),
        .batch          (batch)
    );

    // Accept a request when the buffer is empty or drains this cycle
    assign buf_busy  = idx_reg < buf_reg.count;
    assign pop       = buf_busy && !out_stall;
    assign in_stall  = buf_busy && !(pop && idx_reg + 3'd1 == buf_reg.count);
    assign step      = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        buf_next = buf_reg;
        idx_next = idx_reg;
        if (pop) idx_next = idx_reg + 3'd1;
        if (step) begin
            buf_next = batch;
            idx_next = '0;
        end
    end

    // Hold the result batch and the option registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            buf_reg            <= '0;
            idx_reg            <= '0;
            allow_comments_reg <= 1'b1;
            allow_escape_e_reg <= 1'b1;
        end else begin
            buf_reg <= buf_next;
            idx_reg <= idx_next;
            if (cfg_valid && cfg_index == CFG_ALLOW_COMMENTS) allow_comments_reg <= cfg_data[0];
            if (cfg_valid && cfg_index == CFG_ALLOW_ESCAPE_E) allow_escape_e_reg <= cfg_data[0];
        end
    end

    assign out_valid       = buf_busy;
    assign record_kind     = buf_reg.recs[idx_reg[1:0]].kind;
    assign token_kind      = buf_reg.recs[idx_reg[1:0]].tok;
    assign data_byte       = buf_reg.recs[idx_reg[1:0]].data;
    assign bool_value      = buf_reg.recs[idx_reg[1:0]].bv;
    assign position_row    = buf_reg.recs[idx_reg[1:0]].row;
    assign position_column = buf_reg.recs[idx_reg[1:0]].col;
    assign error_code      = buf_reg.recs[idx_reg[1:0]].err;
    assign last_of_run     = (idx_reg + 3'd1 == buf_reg.count);

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        buf_reg.count <= 3'd4 && idx_reg <= buf_reg.count)
        else $error("result index beyond batch");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |-> in_stall)
        else $error("request taken before batch drained");
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind == REC_ERROR |-> last_of_run)
        else $error("error record not last");

endmodule
